@@ sv/xbau_pkg.sv @@
// ----------------------------------------------------------------------------
// xbau_pkg - shared types and constants for the x86 branch address unfilter
// Holds the beat layout of decoded bytes, the per-cycle result bundle and
// the opcode / address constants used by the converter.
// ----------------------------------------------------------------------------
package xbau_pkg;

   // window and result sizes
   localparam int WIN_DEPTH   = 4;
   localparam int MAX_BEATS   = WIN_DEPTH + 1;
   localparam int FIFO_AW     = 4;
   localparam int FIFO_DEPTH  = 1 << FIFO_AW;
   // room needed for the staged item plus the one being accepted
   localparam int QUEUE_ROOM  = FIFO_DEPTH - 2 * MAX_BEATS;

   // opcode match: E8 (call) and E9 (jmp)
   localparam logic [7:0]  OPC_MASK   = 8'hFE;
   localparam logic [7:0]  OPC_BRANCH = 8'hE8;
   localparam logic [31:0] SPAN_BASE  = 32'h0000_0100;
   localparam logic [31:0] IP_BIAS    = 32'd5;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic [2:0]                      count;
      entry_type [MAX_BEATS-1:0]       entry;
   } push_type;

   // top operand byte that marks a plausible near branch
   function automatic logic plain_byte(input logic [7:0] b);
      return (b == 8'h00) || (b == 8'hFF);
   endfunction

endpackage

@@ sv/xbau_if.sv @@
// ----------------------------------------------------------------------------
// xbau_if - channel interfaces of the x86 branch address unfilter
// Request, response and register-write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface xbau_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, output data_byte, output last, input ready);
   modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface xbau_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface xbau_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_ip;
   modport source (output valid, output start_ip, input ready);
   modport sink   (input valid, input start_ip, output ready);
endinterface

@@ sv/xbau_filter.sv @@
// ----------------------------------------------------------------------------
// xbau_filter - window, opcode test and operand conversion
// Holds the 4-byte look-ahead window and the prefix-mask state, examines
// the oldest byte of each staged beat and hands up to five decoded bytes
// to the output queue in the same cycle.
// ----------------------------------------------------------------------------
module xbau_filter (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  logic [7:0]        step_byte,
   input  logic              step_last,
   input  logic              csr_write,
   input  logic [31:0]       csr_data,
   output xbau_pkg::push_type push
);
   import xbau_pkg::*;

   logic [WIN_DEPTH-1:0][7:0] win_ff, win_in;
   logic [2:0]                held_ff, held_in;
   logic [2:0]                mask_ff, mask_in;
   logic [31:0]               pos_ff, pos_in;
   logic [31:0]               cur_ff, cur_in;
   logic [1:0]                gap_ff, gap_in;
   logic [2:0]                skip_ff, skip_in;
   logic [31:0]               start_ip_ff, start_ip_in;

   logic [MAX_BEATS-1:0][7:0] buf_b, ex_buf, src_buf;
   logic [2:0]                mask_x, skip_x, m, idx;
   logic [1:0]                gap_x;
   logic [31:0]               opnd, v1, v2, v, span;
   logic [7:0]                sel_byte;
   logic                      full;

   assign full = (held_ff == 3'(WIN_DEPTH));

   // current window with the new byte placed after the held ones
   always_comb begin
      buf_b = '0;
      buf_b[WIN_DEPTH-1:0] = win_ff;
      buf_b[held_ff] = step_byte;
   end

   // examine the oldest byte as a possible call/jmp opcode
   always_comb begin
      ex_buf   = buf_b;
      mask_x   = mask_ff;
      gap_x    = gap_ff;
      skip_x   = skip_ff;
      m        = '0;
      idx      = {1'b0, m[2:1]} + 3'd1;
      opnd     = {buf_b[4], buf_b[3], buf_b[2], buf_b[1]};
      v1       = opnd - cur_ff;
      sel_byte = v1[7:0];
      span     = '0;
      v2       = '0;
      v        = v1;
      if (skip_ff != 3'd0) begin
         skip_x = skip_ff - 3'd1;
      end else if ((buf_b[0] & OPC_MASK) != OPC_BRANCH) begin
         if (gap_ff != 2'd3) begin
            gap_x = gap_ff + 2'd1;
         end
      end else begin
         gap_x = 2'd0;
         m     = (gap_ff == 2'd3) ? 3'd0 : (mask_ff >> gap_ff);
         idx   = {1'b0, m[2:1]} + 3'd1;
         // pick the byte checked by the second correction and its span
         case (m[2:1])
            2'd0: sel_byte = v1[7:0];
            2'd1: sel_byte = v1[15:8];
            default: sel_byte = v1[23:16];
         endcase
         span = (SPAN_BASE << {m[2:1], 3'b000}) - 32'd1;
         v2   = (v1 ^ span) - cur_ff;
         if ((m != 3'd0) && ((m > 3'd4) || (m == 3'd3) || plain_byte(buf_b[idx]))) begin
            mask_x = {1'b1, m[2:1]};
         end else if (!plain_byte(buf_b[4])) begin
            mask_x = {1'b1, m[2:1]};
         end else begin
            v         = ((m != 3'd0) && plain_byte(sel_byte)) ? v2 : v1;
            mask_x    = 3'd0;
            skip_x    = 3'd4;
            ex_buf[1] = v[7:0];
            ex_buf[2] = v[15:8];
            ex_buf[3] = v[23:16];
            ex_buf[4] = {8{v[24]}};
         end
      end
   end

   // advance the window, emit beats and clear at the end of a buffer
   always_comb begin
      win_in      = win_ff;
      held_in     = held_ff;
      mask_in     = mask_ff;
      pos_in      = pos_ff;
      cur_in      = cur_ff;
      gap_in      = gap_ff;
      skip_in     = skip_ff;
      start_ip_in = start_ip_ff;
      src_buf     = full ? ex_buf : buf_b;
      push        = '0;
      if (step_valid) begin
         if (!step_last) begin
            if (!full) begin
               win_in[held_ff[1:0]] = step_byte;
               held_in = held_ff + 3'd1;
            end else begin
               push.count         = 3'd1;
               push.entry[0].data = ex_buf[0];
               push.entry[0].last = 1'b0;
               win_in  = ex_buf[MAX_BEATS-1:1];
               mask_in = mask_x;
               gap_in  = gap_x;
               skip_in = skip_x;
               pos_in  = pos_ff + 32'd1;
               cur_in  = cur_ff + 32'd1;
            end
         end else begin
            push.count = held_ff + 3'd1;
            for (int i = 0; i < MAX_BEATS; i++) begin
               push.entry[i].data = src_buf[i];
               push.entry[i].last = (3'(i) == held_ff);
            end
            win_in  = '0;
            held_in = '0;
            mask_in = '0;
            pos_in  = '0;
            gap_in  = '0;
            skip_in = '0;
            cur_in  = start_ip_ff + IP_BIAS;
         end
      end
      if (csr_write) begin
         start_ip_in = csr_data;
         cur_in      = csr_data + IP_BIAS + pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         held_ff     <= '0;
         mask_ff     <= '0;
         pos_ff      <= '0;
         cur_ff      <= IP_BIAS;
         gap_ff      <= '0;
         skip_ff     <= '0;
         start_ip_ff <= '0;
      end else begin
         win_ff      <= win_in;
         held_ff     <= held_in;
         mask_ff     <= mask_in;
         pos_ff      <= pos_in;
         cur_ff      <= cur_in;
         gap_ff      <= gap_in;
         skip_ff     <= skip_in;
         start_ip_ff <= start_ip_in;
      end
   end

endmodule

@@ sv/xbau_out_queue.sv @@
// ----------------------------------------------------------------------------
// xbau_out_queue - result queue of decoded bytes
// Takes up to five beats per cycle from the filter and drains one beat per
// cycle to the response channel while out_ready is high.
// ----------------------------------------------------------------------------
module xbau_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  xbau_pkg::push_type        push,
   input  logic                      out_ready,
   output logic                      out_valid,
   output xbau_pkg::entry_type       out_entry,
   output logic [xbau_pkg::FIFO_AW:0] fill
);
   import xbau_pkg::*;

   entry_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 pop;

   assign out_valid = (count_ff != '0);
   assign out_entry = mem_ff[rd_ptr_ff];
   assign fill      = count_ff;
   assign pop       = out_ready && out_valid;

   assign wr_ptr_in = wr_ptr_ff + FIFO_AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
   assign count_in  = count_ff + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);

   // store the new beats in order behind the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_BEATS; i++) begin
         if (3'(i) < push.count) begin
            mem_ff[wr_ptr_ff + FIFO_AW'(i)] <= push.entry[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/x86_branch_address_unfilter_core.sv @@
// ----------------------------------------------------------------------------
// x86_branch_address_unfilter_core - streaming x86 branch address decoder
//
//   channel   dir  handshake      payload
//   req_bus   in   valid/ready    data_byte[7:0], last
//   rsp_bus   out  valid/ready    out_byte[7:0], out_last
//   csr_bus   in   valid/ready    start_ip[31:0] (always ready)
//
// One byte is taken per cycle while req ready is high; each accepted byte is
// registered in a staging register ahead of the filter, and the first decoded
// byte trails its input by four bytes. A final byte releases up to five beats
// at once, which drain at one beat per cycle while rsp ready is high from the
// 16-entry result queue; req ready drops while it holds more than six beats.
// Reset is synchronous and clears the window, the mask state and start_ip.
// ----------------------------------------------------------------------------
module x86_branch_address_unfilter_core (
   input  logic        clock,
   input  logic        reset,
   xbau_req_if.sink    req_bus,
   xbau_rsp_if.source  rsp_bus,
   xbau_csr_if.sink    csr_bus
);
   import xbau_pkg::*;

   logic              stage_valid_ff;
   logic [7:0]        stage_byte_ff;
   logic              stage_last_ff;
   push_type          push;
   entry_type         head;
   logic [FIFO_AW:0]  fill;
   logic              req_beat;
   logic              csr_beat;

   assign req_bus.ready = (fill <= (FIFO_AW+1)'(QUEUE_ROOM));
   assign csr_bus.ready = 1'b1;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_beat      = csr_bus.valid && csr_bus.ready;

   // hold the accepted beat in the staging register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_beat;
      end
   end

   always_ff @(posedge clock) begin
      stage_byte_ff <= req_bus.data_byte;
      stage_last_ff <= req_bus.last;
   end

   xbau_filter u_filter (
      .clock      (clock),
      .reset      (reset),
      .step_valid (stage_valid_ff),
      .step_byte  (stage_byte_ff),
      .step_last  (stage_last_ff),
      .csr_write  (csr_beat),
      .csr_data   (csr_bus.start_ip),
      .push       (push)
   );

   xbau_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_entry (head),
      .fill      (fill)
   );

   assign rsp_bus.out_byte = head.data;
   assign rsp_bus.out_last = head.last;

`ifndef SYNTH
   // staged beat always finds room for its results
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |-> (fill <= (FIFO_AW+1)'(QUEUE_ROOM + MAX_BEATS)))
      else $error("result queue lacks room for staged beat");

   // only a final byte releases more than one beat
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stage_last_ff) |-> (push.count <= 3'd1))
      else $error("non-final byte released several beats");

   // no beats without a staged byte
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !stage_valid_ff |-> (push.count == 3'd0))
      else $error("beats pushed without a staged byte");

   // a final byte always releases at least its own beat
   a_final_emits: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_last_ff) |-> (push.count != 3'd0))
      else $error("final byte released no beat");
`endif

endmodule
